@@ hdl/scs_pkg.sv @@
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the six-step commutation scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package scs_pkg;

  localparam int unsigned STEPS          = 6;
  localparam int unsigned EVENTS_PER_RUN = STEPS * 3;
  localparam int unsigned MIN_FREE       = STEPS * 3 + 2;
  localparam int unsigned US_PER_MS      = 1000;
  localparam int unsigned HALF_US_PER_MS = 1000 / 2;
  localparam int unsigned RUN_US_PER_MS  = STEPS * US_PER_MS;

  localparam int unsigned MS_W       = 16;
  localparam int unsigned MASK_W     = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned READ_W     = 6;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = $clog2(STEPS);
  localparam int unsigned PULSE_US_W = MS_W + 10;
  localparam int unsigned GAP_US_W   = MS_W + 9;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_AB   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_AC   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_BC   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_BA   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_CA   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_CB   = 4'd7;

  // the three events of one commutation step
  typedef enum logic [1:0] {
    PH_OFF_GAP,
    PH_DRIVE,
    PH_OFF_PULSE
  } phase_t;

  typedef struct packed {
    logic [MS_W-1:0]                   pulse_ms;
    logic [MS_W-1:0]                   period_ms;
    logic [STEPS-1:0][MASK_W-1:0]      mask;
    logic [PULSE_US_W-1:0]             pulse_us;
    logic [GAP_US_W-1:0]               gap_us;
    logic [TIME_W-1:0]                 run_us;
  } cfg_t;

endpackage

`default_nettype wire

@@ hdl/scs_in_if.sv @@
// ----------------------------------------------------------------------------
// scs_in_if
// Trigger channel: current time and the consumer's ring read slot.
// ----------------------------------------------------------------------------
`default_nettype none

interface scs_in_if;
  logic                          valid;
  logic                          ready;
  logic [scs_pkg::TIME_W-1:0]    now_us;
  logic [scs_pkg::READ_W-1:0]    read_index;

  modport source (output valid, output now_us, output read_index, input ready);
  modport sink   (input valid, input now_us, input read_index, output ready);
endinterface

`default_nettype wire

@@ hdl/scs_out_if.sv @@
// ----------------------------------------------------------------------------
// scs_out_if
// Event channel: one timed ring entry per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface scs_out_if;
  logic                             valid;
  logic                             ready;
  logic [scs_pkg::SLOT_OUT_W-1:0]   slot_index;
  logic [scs_pkg::TIME_W-1:0]       event_time_us;
  logic [scs_pkg::MASK_W-1:0]       phase_mask;
  logic                             last_event;

  modport source (output valid, output slot_index, output event_time_us,
                  output phase_mask, output last_event, input ready);
  modport sink   (input valid, input slot_index, input event_time_us,
                  input phase_mask, input last_event, output ready);
endinterface

`default_nettype wire

@@ hdl/scs_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// scs_cfg_regs
// Configuration registers plus registered microsecond timing derived from them.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [scs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output scs_pkg::cfg_t                           cfg
);

  logic [scs_pkg::MS_W-1:0]                       pulse_ms_r;
  logic [scs_pkg::MS_W-1:0]                       period_ms_r;
  logic [scs_pkg::STEPS-1:0][scs_pkg::MASK_W-1:0] mask_r;
  logic [scs_pkg::PULSE_US_W-1:0]                 pulse_us_r;
  logic [scs_pkg::GAP_US_W-1:0]                   gap_us_r;
  logic [scs_pkg::TIME_W-1:0]                     run_us_r;
  logic [scs_pkg::MS_W-1:0]                       pulse_ms_nxt;
  logic [scs_pkg::MS_W-1:0]                       period_ms_nxt;
  logic [scs_pkg::MS_W-1:0]                       diff_ms;
  logic [scs_pkg::PULSE_US_W-1:0]                 pulse_us_nxt;
  logic [scs_pkg::GAP_US_W-1:0]                   gap_us_nxt;
  logic [scs_pkg::TIME_W-1:0]                     run_us_nxt;

  always_comb begin
    // derive from the values being written so timing tracks the registers
    pulse_ms_nxt  = pulse_ms_r;
    period_ms_nxt = period_ms_r;
    if (cfg_we && (cfg_index == scs_pkg::CFG_PULSE_MS)) begin
      pulse_ms_nxt = cfg_wdata;
    end
    if (cfg_we && (cfg_index == scs_pkg::CFG_PERIOD_MS)) begin
      period_ms_nxt = cfg_wdata;
    end
    diff_ms      = period_ms_nxt - pulse_ms_nxt;
    pulse_us_nxt = scs_pkg::PULSE_US_W'(pulse_ms_nxt)
                 * scs_pkg::PULSE_US_W'(scs_pkg::US_PER_MS);
    gap_us_nxt   = scs_pkg::GAP_US_W'(diff_ms)
                 * scs_pkg::GAP_US_W'(scs_pkg::HALF_US_PER_MS);
    // whole run of six steps spans exactly six periods
    run_us_nxt   = scs_pkg::TIME_W'(period_ms_nxt)
                 * scs_pkg::TIME_W'(scs_pkg::RUN_US_PER_MS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ms_r  <= '0;
      period_ms_r <= '0;
      mask_r      <= '0;
      pulse_us_r  <= '0;
      gap_us_r    <= '0;
      run_us_r    <= '0;
    end else begin
      pulse_us_r <= pulse_us_nxt;
      gap_us_r   <= gap_us_nxt;
      run_us_r   <= run_us_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          scs_pkg::CFG_PULSE_MS:  pulse_ms_r  <= cfg_wdata;
          scs_pkg::CFG_PERIOD_MS: period_ms_r <= cfg_wdata;
          scs_pkg::CFG_MASK_AB:   mask_r[0]   <= cfg_wdata;
          scs_pkg::CFG_MASK_AC:   mask_r[1]   <= cfg_wdata;
          scs_pkg::CFG_MASK_BC:   mask_r[2]   <= cfg_wdata;
          scs_pkg::CFG_MASK_BA:   mask_r[3]   <= cfg_wdata;
          scs_pkg::CFG_MASK_CA:   mask_r[4]   <= cfg_wdata;
          scs_pkg::CFG_MASK_CB:   mask_r[5]   <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    cfg.pulse_ms  = pulse_ms_r;
    cfg.period_ms = period_ms_r;
    cfg.mask      = mask_r;
    cfg.pulse_us  = pulse_us_r;
    cfg.gap_us    = gap_us_r;
    cfg.run_us    = run_us_r;
  end

endmodule

`default_nettype wire

@@ hdl/scs_front.sv @@
// ----------------------------------------------------------------------------
// scs_front
// Accepts triggers, checks timing and ring space, picks the start time and
// books ring slots; passes each run to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_front #(
  parameter int unsigned RING_SLOTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  scs_in_if.sink                             in_ch,
  input  wire scs_pkg::cfg_t                 cfg,
  input  wire logic                          q_full,
  output logic                               q_push,
  output logic [scs_pkg::TIME_W+$clog2(RING_SLOTS)-1:0] q_data
);

  localparam int unsigned IDX_W    = $clog2(RING_SLOTS);
  localparam int unsigned FW       = IDX_W + 1;
  localparam int unsigned RW       = ((IDX_W > scs_pkg::READ_W) ? IDX_W : scs_pkg::READ_W) + 1;
  localparam int unsigned RD_STEPS = (1 << scs_pkg::READ_W) / RING_SLOTS + 1;

  logic [IDX_W-1:0]            wr_r,   wr_nxt;
  logic [scs_pkg::TIME_W-1:0]  last_r, last_nxt;
  logic [RW-1:0]               rd_ext;
  logic [IDX_W-1:0]            rd;
  logic [FW-1:0]               free_slots;
  logic [FW-1:0]               wr_sum;
  logic [scs_pkg::TIME_W-1:0]  t_base;
  logic [scs_pkg::TIME_W-1:0]  start;
  logic                        timing_ok;
  logic                        space_ok;
  logic                        xfer;

  always_comb begin
    // reduce the read slot into the ring
    rd_ext = RW'(in_ch.read_index);
    for (int i = 0; i < RD_STEPS; i++) begin
      if (rd_ext >= RW'(RING_SLOTS)) begin
        rd_ext = rd_ext - RW'(RING_SLOTS);
      end
    end
    rd = rd_ext[IDX_W-1:0];

    if (rd == wr_r) begin
      free_slots = FW'(RING_SLOTS);
    end else if (rd > wr_r) begin
      free_slots = FW'(rd) - FW'(wr_r);
    end else begin
      free_slots = FW'(rd) + FW'(RING_SLOTS) - FW'(wr_r);
    end

    timing_ok = (cfg.pulse_ms != '0) && (cfg.pulse_ms <= cfg.period_ms);
    space_ok  = free_slots >= FW'(scs_pkg::MIN_FREE);

    // an empty ring restarts from now
    t_base = (rd == wr_r) ? '0 : last_r;
    start  = (in_ch.now_us > t_base) ? in_ch.now_us : t_base;

    wr_sum = FW'(wr_r) + FW'(scs_pkg::EVENTS_PER_RUN);
    if (wr_sum >= FW'(RING_SLOTS)) begin
      wr_sum = wr_sum - FW'(RING_SLOTS);
    end
    wr_nxt   = wr_sum[IDX_W-1:0];
    last_nxt = start + cfg.run_us;
  end

  assign in_ch.ready = !q_full;
  assign xfer        = in_ch.valid && !q_full;
  assign q_push      = xfer && timing_ok && space_ok;
  assign q_data      = {start, wr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      last_r <= '0;
    end else if (q_push) begin
      wr_r   <= wr_nxt;
      last_r <= last_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scs_queue.sv @@
// ----------------------------------------------------------------------------
// scs_queue
// Two-entry queue of booked runs between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_queue #(
  parameter int unsigned W = 38
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire logic [W-1:0]  push_data,
  input  wire logic          pop,
  output logic               q_valid,
  output logic               q_full,
  output logic [W-1:0]       q_data
);

  logic [1:0][W-1:0] ent_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic              head_r;
  logic              tail_r;

  assign q_valid = cnt_r != 2'd0;
  assign q_full  = cnt_r == 2'd2;
  assign q_data  = ent_r[head_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(pop && q_valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && pop && q_valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      head_r <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        tail_r <= !tail_r;
      end
      if (pop && q_valid) begin
        head_r <= !head_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[tail_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/scs_back.sv @@
// ----------------------------------------------------------------------------
// scs_back
// Sequencer that walks six steps of three events each, accumulating time
// and slot, into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scs_back #(
  parameter int unsigned RING_SLOTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire scs_pkg::cfg_t                 cfg,
  input  wire logic                          q_valid,
  input  wire logic [scs_pkg::TIME_W+$clog2(RING_SLOTS)-1:0] q_data,
  output logic                               q_pop,
  scs_out_if.source                          out_ch
);

  localparam int unsigned IDX_W = $clog2(RING_SLOTS);

  logic                              busy_r;
  scs_pkg::phase_t                   phase_r;
  logic [scs_pkg::STEP_W-1:0]        step_r;
  logic [scs_pkg::TIME_W-1:0]        t_r;
  logic [IDX_W-1:0]                  slot_r;
  logic                              out_valid_r;
  logic [scs_pkg::SLOT_OUT_W-1:0]    out_slot_r;
  logic [scs_pkg::TIME_W-1:0]        out_time_r;
  logic [scs_pkg::MASK_W-1:0]        out_mask_r;
  logic                              out_last_r;

  logic                              advance;
  logic                              last_ev;
  logic [scs_pkg::TIME_W-1:0]        t_nxt;
  logic [IDX_W-1:0]                  slot_nxt;
  logic [scs_pkg::MASK_W-1:0]        mask_nxt;

  always_comb begin
    advance = busy_r && (!out_valid_r || out_ch.ready);
    last_ev = (step_r == scs_pkg::STEP_W'(scs_pkg::STEPS - 1))
           && (phase_r == scs_pkg::PH_OFF_PULSE);
    q_pop   = q_valid && (!busy_r || (advance && last_ev));

    if (phase_r == scs_pkg::PH_OFF_PULSE) begin
      t_nxt = t_r + scs_pkg::TIME_W'(cfg.pulse_us);
    end else begin
      t_nxt = t_r + scs_pkg::TIME_W'(cfg.gap_us);
    end

    slot_nxt = (slot_r == IDX_W'(RING_SLOTS - 1)) ? '0 : slot_r + IDX_W'(1);
    mask_nxt = (phase_r == scs_pkg::PH_DRIVE) ? cfg.mask[step_r] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= scs_pkg::PH_OFF_GAP;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (q_pop) begin
        busy_r  <= 1'b1;
        phase_r <= scs_pkg::PH_OFF_GAP;
        step_r  <= '0;
      end else if (advance) begin
        if (last_ev) begin
          busy_r <= 1'b0;
        end
        unique case (phase_r)
          scs_pkg::PH_OFF_GAP: phase_r <= scs_pkg::PH_DRIVE;
          scs_pkg::PH_DRIVE:   phase_r <= scs_pkg::PH_OFF_PULSE;
          scs_pkg::PH_OFF_PULSE: begin
            phase_r <= scs_pkg::PH_OFF_GAP;
            step_r  <= step_r + scs_pkg::STEP_W'(1);
          end
          default: phase_r <= scs_pkg::PH_OFF_GAP;
        endcase
      end
    end
  end

  // payload: time and slot accumulators, output stage
  always_ff @(posedge clk) begin
    if (q_pop) begin
      t_r    <= q_data[scs_pkg::TIME_W+IDX_W-1:IDX_W];
      slot_r <= q_data[IDX_W-1:0];
    end else if (advance) begin
      t_r    <= t_nxt;
      slot_r <= slot_nxt;
    end
    if (advance) begin
      out_slot_r <= scs_pkg::SLOT_OUT_W'(slot_r);
      out_time_r <= t_nxt;
      out_mask_r <= mask_nxt;
      out_last_r <= last_ev;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.slot_index    = out_slot_r;
  assign out_ch.event_time_us = out_time_r;
  assign out_ch.phase_mask    = out_mask_r;
  assign out_ch.last_event    = out_last_r;

endmodule

`default_nettype wire

@@ hdl/six_step_commutation_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// six_step_commutation_scheduler_core
// Turns each motor trigger into eighteen timed ring entries (six commutation
// steps of off / drive / off) when timing is valid and the ring has room.
//
//   Channel   Direction  Carries                                   Transfer
//   in_ch     sink       now_us, read_index                        valid & ready
//   out_ch    source     slot_index, event_time_us, phase_mask,    valid & ready
//                        last_event
//   cfg_*     sink       cfg_index, cfg_wdata                      cfg_we
//
// A run yields one entry per cycle while the output is ready, paced by the
// back-end sequencer's single time adder. Rejected triggers yield nothing.
// Up to two booked runs wait in the queue while the output stalls; the front
// keeps taking triggers until it fills. Reset is synchronous and clears the
// control and config registers but not the payload, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module six_step_commutation_scheduler_core #(
  parameter int unsigned RING_SLOTS = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  scs_in_if.sink                               in_ch,
  scs_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [scs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [scs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned QW = scs_pkg::TIME_W + $clog2(RING_SLOTS);

  scs_pkg::cfg_t   cfg;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  logic            q_full;
  logic [QW-1:0]   push_data;
  logic [QW-1:0]   q_data;

  scs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  scs_front #(.RING_SLOTS(RING_SLOTS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (push_data)
  );

  scs_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_full    (q_full),
    .q_data    (q_data)
  );

  scs_back #(.RING_SLOTS(RING_SLOTS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

@@ test/tb_six_step_commutation_scheduler_core.sv @@
// ----------------------------------------------------------------------------
// tb_six_step_commutation_scheduler_core
// Drives motor triggers into the commutation scheduler under a series of
// timing and mask settings. Each accepted trigger is run through a local
// model of the ring scheduler, and every event that leaves the block is
// checked against the oldest predicted entry. Both channels idle at random,
// and in one phase the event side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_six_step_commutation_scheduler_core;

  localparam int unsigned RING_SLOTS = 64;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [scs_pkg::TIME_W-1:0] now_us;
    logic [scs_pkg::READ_W-1:0] read_index;
  } trigger_t;

  typedef struct packed {
    logic [scs_pkg::SLOT_OUT_W-1:0] slot_index;
    logic [scs_pkg::TIME_W-1:0]     event_time_us;
    logic [scs_pkg::MASK_W-1:0]     phase_mask;
    logic                           last_event;
  } ring_event_t;

  typedef struct packed {
    logic [31:0]                wr_slot;
    logic [scs_pkg::TIME_W-1:0] last_us;
  } ring_state_t;

  typedef struct packed {
    logic [4:0]                                count;
    ring_state_t                               next;
    ring_event_t [scs_pkg::EVENTS_PER_RUN-1:0] events;
  } run_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           trig_valid = 1'b0;
  logic [scs_pkg::TIME_W-1:0]     trig_now = '0;
  logic [scs_pkg::READ_W-1:0]     trig_read = '0;
  logic                           ev_ready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [scs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [scs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  scs_in_if  in_ch ();
  scs_out_if out_ch ();

  assign in_ch.valid      = trig_valid;
  assign in_ch.now_us     = trig_now;
  assign in_ch.read_index = trig_read;
  assign out_ch.ready     = ev_ready;

  six_step_commutation_scheduler_core #(
    .RING_SLOTS(RING_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the block's registers and ring state
  logic [scs_pkg::MS_W-1:0]                       pulse_cfg = '0;
  logic [scs_pkg::MS_W-1:0]                       period_cfg = '0;
  logic [scs_pkg::STEPS-1:0][scs_pkg::MASK_W-1:0] step_mask = '0;
  ring_state_t                                    ring_state = '0;
  ring_state_t                                    plan_state = '0;

  trigger_t    pending_triggers[$];
  ring_event_t expected_events[$];

  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  int unsigned trig_gap = 0;
  int unsigned ev_stall = 0;
  int unsigned ev_hold = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  run_t        accepted_run;

  function automatic run_t schedule_run(trigger_t trg, ring_state_t st);
    run_t                       r;
    int unsigned                rd;
    int unsigned                wr;
    int unsigned                room;
    int unsigned                slot;
    logic [scs_pkg::TIME_W-1:0] t;
    logic [scs_pkg::TIME_W-1:0] pulse_us;
    logic [scs_pkg::TIME_W-1:0] gap_us;
    scs_pkg::phase_t            ph;
    r = '0;
    r.next = st;
    rd = trg.read_index % RING_SLOTS;
    wr = st.wr_slot % RING_SLOTS;
    if (pulse_cfg == 0 || pulse_cfg > period_cfg) return r;
    room = (rd + RING_SLOTS - wr) % RING_SLOTS;
    if (room == 0) room = RING_SLOTS;
    if (room < scs_pkg::MIN_FREE) return r;
    // an empty ring starts from now, otherwise from the later of now and the last entry
    t = (rd == wr) ? '0 : st.last_us;
    if (trg.now_us > t) t = trg.now_us;
    pulse_us = scs_pkg::TIME_W'(pulse_cfg) * scs_pkg::US_PER_MS;
    gap_us = (scs_pkg::TIME_W'(period_cfg) - scs_pkg::TIME_W'(pulse_cfg))
           * scs_pkg::HALF_US_PER_MS;
    slot = wr;
    for (int k = 0; k < scs_pkg::EVENTS_PER_RUN; k++) begin
      ph = scs_pkg::phase_t'(k % 3);
      r.events[k].phase_mask = '0;
      case (ph)
        scs_pkg::PH_OFF_GAP: begin
          t = t + gap_us;
        end
        scs_pkg::PH_DRIVE: begin
          t = t + gap_us;
          r.events[k].phase_mask = step_mask[k / 3];
        end
        default: begin
          t = t + pulse_us;
        end
      endcase
      r.events[k].slot_index = scs_pkg::SLOT_OUT_W'(slot);
      r.events[k].event_time_us = t;
      r.events[k].last_event = (k == scs_pkg::EVENTS_PER_RUN - 1);
      slot = (slot + 1) % RING_SLOTS;
    end
    r.count = 5'(scs_pkg::EVENTS_PER_RUN);
    r.next.wr_slot = slot;
    r.next.last_us = t;
    return r;
  endfunction

  // trigger side
  always @(posedge clk) begin
    if (!rst_n) begin
      trig_valid <= 1'b0;
    end else if (!trig_valid || in_ch.ready) begin
      if (trig_valid) begin
        accepted_run = schedule_run('{trig_now, trig_read}, ring_state);
        ring_state = accepted_run.next;
        for (int k = 0; k < accepted_run.count; k++)
          expected_events.push_back(accepted_run.events[k]);
      end
      if (trig_gap > 0) begin
        trig_gap = trig_gap - 1;
        trig_valid <= 1'b0;
      end else if (pending_triggers.size() == 0) begin
        trig_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        trig_gap = $urandom_range(1, 12) - 1;
        trig_valid <= 1'b0;
      end else begin
        trig_now <= pending_triggers[0].now_us;
        trig_read <= pending_triggers[0].read_index;
        trig_valid <= 1'b1;
        void'(pending_triggers.pop_front());
      end
    end
  end

  // event side
  always @(posedge clk) begin
    ring_event_t got;
    ring_event_t want;
    if (!rst_n) begin
      ev_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.slot_index, out_ch.event_time_us, out_ch.phase_mask,
                out_ch.last_event};
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event slot %0d time %h mask %h last %b", $time,
                   got.slot_index, got.event_time_us, got.phase_mask, got.last_event);
          failures++;
        end else begin
          want = expected_events.pop_front();
          if (got !== want) begin
            $display("%0t: event mismatch: expected slot %0d time %h mask %h last %b",
                     $time, want.slot_index, want.event_time_us, want.phase_mask,
                     want.last_event);
            $display("%0t:                 actual   slot %0d time %h mask %h last %b",
                     $time, got.slot_index, got.event_time_us, got.phase_mask,
                     got.last_event);
            failures++;
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        ev_hold = HOLD_CYCLES;
      end
      if (ev_hold > 0) begin
        ev_hold = ev_hold - 1;
        ev_ready <= 1'b0;
      end else if (ev_stall > 0) begin
        ev_stall = ev_stall - 1;
        ev_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        ev_stall = $urandom_range(1, 12) - 1;
        ev_ready <= 1'b0;
      end else begin
        ev_ready <= 1'b1;
      end
    end
  end

  // watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [scs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [scs_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx) inside
      scs_pkg::CFG_PULSE_MS:  pulse_cfg = val;
      scs_pkg::CFG_PERIOD_MS: period_cfg = val;
      scs_pkg::CFG_MASK_AB, scs_pkg::CFG_MASK_AC, scs_pkg::CFG_MASK_BC,
      scs_pkg::CFG_MASK_BA, scs_pkg::CFG_MASK_CA, scs_pkg::CFG_MASK_CB:
        step_mask[idx - scs_pkg::CFG_MASK_AB] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_timing(input int unsigned pulse, input int unsigned period);
    write_reg(scs_pkg::CFG_PULSE_MS, scs_pkg::CFG_DATA_W'(pulse));
    write_reg(scs_pkg::CFG_PERIOD_MS, scs_pkg::CFG_DATA_W'(period));
  endtask

  // hold until every transfer has drained, then let rejected triggers retire
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_triggers.size() != 0 || trig_valid || expected_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    plan_state = ring_state;
  endtask

  function automatic logic [scs_pkg::READ_W-1:0] read_ahead(input int unsigned ahead);
    return scs_pkg::READ_W'((plan_state.wr_slot + ahead) % RING_SLOTS);
  endfunction

  task automatic offer(input logic [scs_pkg::TIME_W-1:0] now_us,
                       input logic [scs_pkg::READ_W-1:0] rd);
    trigger_t trg;
    trg = '{now_us, rd};
    plan_state = schedule_run(trg, plan_state).next;
    pending_triggers.push_back(trg);
  endtask

  task automatic random_phase(input int unsigned n_items);
    int unsigned                pick;
    int unsigned                pulse;
    int unsigned                period;
    logic [scs_pkg::TIME_W-1:0] now_us;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        pulse = 0;
        period = $urandom_range(0, 65535);
      end
      1: begin
        period = $urandom_range(0, 65534);
        pulse = $urandom_range(period + 1, 65535);
      end
      2: begin
        pulse = 65535;
        period = 65535;
      end
      3: begin
        pulse = 1;
        period = 65535;
      end
      default: begin
        pulse = $urandom_range(1, 200);
        period = pulse + $urandom_range(0, 300);
      end
    endcase
    set_timing(pulse, period);
    for (int s = 0; s < scs_pkg::STEPS; s++)
      write_reg(scs_pkg::CFG_IDX_W'(scs_pkg::CFG_MASK_AB + s),
                scs_pkg::CFG_DATA_W'($urandom));
    write_reg(scs_pkg::CFG_IDX_W'(scs_pkg::CFG_MASK_CB + $urandom_range(1, 8)),
              scs_pkg::CFG_DATA_W'($urandom));
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 9);
      if ($urandom_range(0, 1) == 0)
        now_us = plan_state.last_us - $urandom_range(0, 5000);
      else
        now_us = plan_state.last_us + $urandom_range(0, 100000);
      case (pick)
        7: offer(now_us, read_ahead($urandom_range(1, scs_pkg::MIN_FREE - 1)));
        8: offer($urandom, scs_pkg::READ_W'($urandom));
        9: offer($urandom_range(0, 1) ? '1 : '0,
                 read_ahead($urandom_range(scs_pkg::MIN_FREE, 64)));
        default: offer(now_us, read_ahead($urandom_range(scs_pkg::MIN_FREE, 64)));
      endcase
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers at reset: pulse zero disables
    offer(32'h0000_1000, 6'd0);
    offer('1, 6'd40);
    wait_idle();

    // pulse longer than period
    write_reg(scs_pkg::CFG_MASK_AB, 16'hFFFF);
    write_reg(scs_pkg::CFG_MASK_AC, 16'h0000);
    write_reg(scs_pkg::CFG_MASK_BC, 16'hAAAA);
    write_reg(scs_pkg::CFG_MASK_BA, 16'h5555);
    write_reg(scs_pkg::CFG_MASK_CA, 16'h8001);
    write_reg(scs_pkg::CFG_MASK_CB, 16'h7FFE);
    set_timing(5, 3);
    offer(32'h0000_0100, 6'd0);
    wait_idle();

    // no gap between off and drive
    set_timing(1, 1);
    offer('0, read_ahead(0));
    offer('1, read_ahead(0));
    offer('0, read_ahead(scs_pkg::MIN_FREE));
    offer('0, read_ahead(scs_pkg::MIN_FREE - 1));
    offer(32'd123, read_ahead(1));
    offer(32'd5, 6'd63);
    offer(32'd123, read_ahead(40));
    wait_idle();

    // longest pulse, and registers outside the map
    set_timing(65535, 65535);
    write_reg(scs_pkg::CFG_IDX_W'(scs_pkg::CFG_MASK_CB + 1), 16'hFFFF);
    write_reg('1, 16'h1234);
    offer('1, read_ahead(0));
    offer('0, read_ahead(63));
    offer(32'h8000_0000, read_ahead(scs_pkg::MIN_FREE));
    wait_idle();

    // widest gap
    set_timing(1, 65535);
    offer(32'hFFFF_0000, read_ahead(0));
    offer(32'h0000_0001, read_ahead(scs_pkg::MIN_FREE));
    offer(32'hFFFF_FFFE, read_ahead(50));
    wait_idle();

    set_timing(65535, 65534);
    offer(32'h0000_0010, read_ahead(0));
    wait_idle();

    for (int p = 0; p < 9; p++) begin
      if (p == 3) hold_req = 1'b1;
      if (p == 8) quiet = 1'b1;
      random_phase(52);
    end

    if (failures == 0 && expected_events.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/scs_pkg.sv
hdl/scs_in_if.sv
hdl/scs_out_if.sv
hdl/scs_cfg_regs.sv
hdl/scs_front.sv
hdl/scs_queue.sv
hdl/scs_back.sv
hdl/six_step_commutation_scheduler_core.sv
test/tb_six_step_commutation_scheduler_core.sv
